// ===== hdl/max_heap_priority_queue_assert.svh =====
// Assertion macros used by the priority queue top level.
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define MHPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next one.
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mhpq_pkg.sv =====
// Shared types and constants of the max-heap priority queue.
`timescale 1ns / 1ps
`default_nettype none
package mhpq_pkg;

  localparam int KEY_W       = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    key_t                   top_value;
    logic [COUNT_OUT_W-1:0] count;
    logic                   full_error;
    logic                   empty_error;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/mhpq_ram.sv =====
// Heap entry store: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module mhpq_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AW-1:0]  waddr,
  input  wire mhpq_pkg::key_t wdata,
  input  wire logic [AW-1:0]  raddr_a,
  input  wire logic [AW-1:0]  raddr_b,
  output mhpq_pkg::key_t      rdata_a,
  output mhpq_pkg::key_t      rdata_b
);
  import mhpq_pkg::*;

  key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ===== hdl/mhpq_engine.sv =====
// Sift-up / sift-down sequencer around the heap store.
`timescale 1ns / 1ps
`default_nettype none
module mhpq_engine #(
  parameter int HEAP_DEPTH = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_op,
  input  wire mhpq_pkg::key_t in_value,
  output logic                res_valid,
  input  wire logic           res_ready,
  output mhpq_pkg::result_t   res
);
  import mhpq_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int PW = $clog2(HEAP_DEPTH + 1);
  localparam logic [PW-1:0] SLOT_ROOT = PW'(1);
  localparam logic [PW-1:0] SLOT_FULL = PW'(HEAP_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_RD  = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_LOAD   = 3'd3;
  localparam logic [2:0] S_DN_RD  = 3'd4;
  localparam logic [2:0] S_DN_CMP = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]    state;
  logic [PW-1:0] count;
  logic [PW-1:0] pos;
  key_t          key;
  key_t          root;
  logic          full_err;
  logic          empty_err;

  logic [PW-1:0] pos_m1;
  logic [PW-1:0] count_m1;
  logic [PW-1:0] parent;
  logic [PW-1:0] parent_m1;
  logic [PW:0]   l_slot;
  logic [PW:0]   r_slot;
  logic [PW:0]   l_m1;
  logic [PW:0]   count_ext;
  logic          l_in;
  logic          r_in;
  logic          up_gt;
  logic          l_gt;
  logic          r_gt;
  key_t          big_lk;
  logic [PW+COUNT_OUT_W-1:0] count_wide;

  logic          we;
  logic [AW-1:0] waddr;
  key_t          wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  key_t          rdata_a;
  key_t          rdata_b;

  mhpq_ram #(
    .DEPTH (HEAP_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // slot s lives at address s - 1
  assign pos_m1    = pos - 1'b1;
  assign count_m1  = count - 1'b1;
  assign parent    = {1'b0, pos[PW-1:1]};
  assign parent_m1 = parent - 1'b1;
  assign l_slot    = {pos, 1'b0};
  assign r_slot    = {pos, 1'b1};
  assign l_m1      = {pos_m1, 1'b1};
  assign count_ext = {1'b0, count};
  assign l_in      = (l_slot <= count_ext);
  assign r_in      = (r_slot <= count_ext);

  assign up_gt  = (key > rdata_a);
  assign l_gt   = (rdata_a > key);
  assign big_lk = l_gt ? rdata_a : key;
  assign r_gt   = r_in && (rdata_b > big_lk);

  always_comb begin
    we      = 1'b0;
    waddr   = pos_m1[AW-1:0];
    wdata   = key;
    raddr_a = count_m1[AW-1:0];
    raddr_b = l_slot[AW-1:0];
    case (state)
      S_UP_RD: begin
        if (pos == SLOT_ROOT) begin
          we = 1'b1;
        end else begin
          raddr_a = parent_m1[AW-1:0];
        end
      end
      S_UP_CMP: begin
        // move the parent down into the hole, or drop the key here
        we    = 1'b1;
        wdata = up_gt ? rdata_a : key;
      end
      S_DN_RD: begin
        if (l_in) begin
          raddr_a = l_m1[AW-1:0];
        end else begin
          we = 1'b1;
        end
      end
      S_DN_CMP: begin
        we    = 1'b1;
        wdata = r_gt ? rdata_b : big_lk;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            full_err  <= 1'b0;
            empty_err <= 1'b0;
            if (in_op == OP_INSERT) begin
              if (count == SLOT_FULL) begin
                full_err <= 1'b1;
                state    <= S_DONE;
              end else begin
                key   <= in_value;
                count <= count + 1'b1;
                pos   <= count + 1'b1;
                state <= S_UP_RD;
              end
            end else begin
              if (count == '0) begin
                empty_err <= 1'b1;
                state     <= S_DONE;
              end else begin
                count <= count_m1;
                pos   <= SLOT_ROOT;
                state <= S_LOAD;
              end
            end
          end
        end
        S_LOAD: begin
          key   <= rdata_a;
          state <= S_DN_RD;
        end
        S_UP_RD: begin
          state <= (pos == SLOT_ROOT) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (up_gt) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_RD: begin
          state <= l_in ? S_DN_CMP : S_DONE;
        end
        S_DN_CMP: begin
          if (r_gt) begin
            pos   <= r_slot[PW-1:0];
            state <= S_DN_RD;
          end else if (l_gt) begin
            pos   <= l_slot[PW-1:0];
            state <= S_DN_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // shadow copy of the root slot
  always_ff @(posedge clk) begin
    if (we && (waddr == '0)) begin
      root <= wdata;
    end
  end

  assign count_wide = {{COUNT_OUT_W{1'b0}}, count};

  assign in_ready        = (state == S_IDLE);
  assign res_valid       = (state == S_DONE);
  assign res.top_value   = (count != '0) ? root : '0;
  assign res.count       = count_wide[COUNT_OUT_W-1:0];
  assign res.full_error  = full_err;
  assign res.empty_error = empty_err;

endmodule
`default_nettype wire

// ===== hdl/max_heap_priority_queue.sv =====
// Max-heap priority queue top level: stream ports and result register.
//
// Input stream s_axis: one word per operation. tuser carries the operation
// (0 insert tdata as a signed key, 1 remove the maximum).
// Output stream m_axis: one word per operation with the maximum key, the
// occupancy and two error flags (insert into a full heap is dropped, remove
// from an empty heap changes nothing).
// The heap lives in a single memory with one write and two registered read
// ports. An insert puts its key in the new last slot and climbs: each level
// reads the parent, then moves the parent down into the hole or drops the key.
// A remove loads the last key, then sinks it from the root: each level reads
// both children, then moves the larger child up if it beats the key (the left
// child wins a tie) or drops the key. Errors go straight to the result. One
// item is in work at a time; s_axis_tready is high while the sequencer is idle.
// A finished result waits in an output register, so the next word is taken
// while m_axis stalls; a second result waits in the sequencer until the
// register frees up.
// Reset empties the heap; memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module max_heap_priority_queue #(
  parameter int HEAP_DEPTH = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [mhpq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // value[31:0]
  input  wire logic                                s_axis_tuser,  // operation
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [mhpq_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,  // top_value[31:0], count[38:32]
  output logic [mhpq_pkg::OUT_TUSER_W-1:0]         m_axis_tuser   // full_error[0], empty_error[1]
);
  import mhpq_pkg::*;

  `include "max_heap_priority_queue_assert.svh"

  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_res;
  logic    out_valid;

  mhpq_engine #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_value  (s_axis_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the word until the receiver takes it
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res.count, out_res.top_value};
  assign m_axis_tuser  = {out_res.empty_error, out_res.full_error};

  `MHPQ_ASSERT(a_err_exclusive, !(out_valid && out_res.full_error && out_res.empty_error), "both error flags set")
  `MHPQ_ASSERT(a_empty_err_count, !(out_valid && out_res.empty_error) || (out_res.count == '0), "empty error with nonzero count")
  `MHPQ_ASSERT(a_empty_top_zero, !(out_valid && (out_res.count == '0) && !out_res.empty_error && !out_res.full_error && (HEAP_DEPTH < 128)) || (out_res.top_value == '0), "empty heap reports nonzero top")
  `MHPQ_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "sequencer took a second word while busy")

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the max-heap priority queue stream block.
`timescale 1ns / 1ps
module testbench;
  import mhpq_pkg::*;

  localparam int HEAP_DEPTH   = 64;
  localparam int RANDOM_WORDS = 1750;
  localparam int QUIET_TAIL   = 200;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 60;
  localparam key_t KEY_MAX    = 32'sh7FFF_FFFF;
  localparam key_t KEY_MIN    = 32'sh8000_0000;

  typedef struct {
    logic    op;
    key_t    val;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // value[31:0]
  logic                   s_axis_tuser;   // operation
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // top_value[31:0], count[38:32]
  logic [OUT_TUSER_W-1:0] m_axis_tuser;   // full_error[0], empty_error[1]

  // shadow heap, one-based like the block's store
  key_t      heap_keys [1:HEAP_DEPTH];
  int        heap_fill;
  result_t   pending_results[$];
  stim_row_t directed_rows[$];
  int        mismatch_count;
  bit        idle_on;
  bit        hold_out;

  max_heap_priority_queue #(.HEAP_DEPTH(HEAP_DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Apply one operation to the shadow heap and return the word it produces.
  function automatic result_t heap_apply(input logic op, input key_t val);
    result_t r;
    int      pos;
    int      up;
    int      lc;
    int      big;
    key_t    t;
    r = '0;
    if (op == OP_INSERT) begin
      if (heap_fill >= HEAP_DEPTH) begin
        r.full_error = 1'b1;
      end else begin
        heap_fill++;
        pos = heap_fill;
        heap_keys[pos] = val;
        while (pos > 1) begin
          up = pos >> 1;
          if (!(heap_keys[pos] > heap_keys[up])) break;
          t = heap_keys[pos];
          heap_keys[pos] = heap_keys[up];
          heap_keys[up] = t;
          pos = up;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        r.empty_error = 1'b1;
      end else begin
        heap_keys[1] = heap_keys[heap_fill];
        heap_fill--;
        pos = 1;
        forever begin
          lc = pos * 2;
          big = pos;
          if (lc <= heap_fill && heap_keys[lc] > heap_keys[big]) big = lc;
          if (lc + 1 <= heap_fill && heap_keys[lc + 1] > heap_keys[big]) big = lc + 1;
          if (big == pos) break;
          t = heap_keys[pos];
          heap_keys[pos] = heap_keys[big];
          heap_keys[big] = t;
          pos = big;
        end
      end
    end
    r.top_value = (heap_fill != 0) ? heap_keys[1] : '0;
    r.count     = COUNT_OUT_W'(heap_fill);
    return r;
  endfunction

  task automatic add_row(input logic op, input key_t val, input bit typed = 1'b0,
                         input key_t top = '0, input int cnt = 0,
                         input logic ferr = 1'b0, input logic eerr = 1'b0);
    stim_row_t row;
    row.op                = op;
    row.val               = val;
    row.typed             = typed;
    row.want.top_value    = top;
    row.want.count        = COUNT_OUT_W'(cnt);
    row.want.full_error   = ferr;
    row.want.empty_error  = eerr;
    directed_rows.push_back(row);
  endtask

  // Offer one word and return once it is taken.
  task automatic offer_word(input logic op, input key_t val);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = val;
    s_axis_tuser  = op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  function automatic key_t pick_key();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return KEY_MAX;
          1: return KEY_MIN;
          2: return '0;
          default: return -1;
        endcase
      end
      1, 2: return key_t'($urandom_range(0, 8)) - 4;  // dense range forces ties
      default: return key_t'($urandom);
    endcase
  endfunction

  // Output side: ready with short random stalls, one long hold on request.
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_out) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_out = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: tdata=%h tuser=%b",
               m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== want.top_value) begin
          $error("top_value: expected %0d, got %0d", want.top_value,
                 $signed(m_axis_tdata[31:0]));
          mismatch_count++;
        end
        if (m_axis_tdata[38:32] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, m_axis_tdata[38:32]);
          mismatch_count++;
        end
        if (m_axis_tuser[0] !== want.full_error) begin
          $error("full_error: expected %b, got %b", want.full_error, m_axis_tuser[0]);
          mismatch_count++;
        end
        if (m_axis_tuser[1] !== want.empty_error) begin
          $error("empty_error: expected %b, got %b", want.empty_error, m_axis_tuser[1]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("max_heap_priority_queue verification failed");
    $finish;
  end

  initial begin
    result_t predicted;
    logic    op;
    key_t    val;
    int      sent;
    int      seg;
    int      seg_len;
    int      insert_pct;
    int      hold_at;
    int      pause_at;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_INSERT;
    heap_fill     = 0;
    mismatch_count = 0;
    idle_on       = 1'b1;
    hold_out      = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    //       op         value              typed top       cnt ferr eerr
    add_row(OP_REMOVE, 32'sh1234_5678,     1'b1, 0,        0,  0,   1);
    add_row(OP_INSERT, KEY_MAX,            1'b1, KEY_MAX,  1,  0,   0);
    add_row(OP_INSERT, KEY_MIN,            1'b1, KEY_MAX,  2,  0,   0);
    add_row(OP_REMOVE, 32'sh0,             1'b1, KEY_MIN,  1,  0,   0);
    add_row(OP_REMOVE, -1,                 1'b1, 0,        0,  0,   0);
    add_row(OP_REMOVE, KEY_MAX,            1'b1, 0,        0,  0,   1);
    add_row(OP_INSERT, KEY_MIN,            1'b1, KEY_MIN,  1,  0,   0);
    add_row(OP_INSERT, -1);
    add_row(OP_INSERT, 0);
    add_row(OP_INSERT, 1);
    add_row(OP_INSERT, 1);
    add_row(OP_INSERT, 1);
    add_row(OP_INSERT, 32'sh5555_5555);
    add_row(OP_INSERT, 32'shAAAA_AAAA);
    add_row(OP_REMOVE, -1);
    add_row(OP_REMOVE, KEY_MIN);
    add_row(OP_INSERT, 7);
    add_row(OP_INSERT, 7);
    add_row(OP_REMOVE, 0);
    add_row(OP_INSERT, KEY_MAX);
    add_row(OP_INSERT, KEY_MAX);
    add_row(OP_REMOVE, 0);
    add_row(OP_REMOVE, 0);

    foreach (directed_rows[i]) begin
      offer_word(directed_rows[i].op, directed_rows[i].val);
      predicted = heap_apply(directed_rows[i].op, directed_rows[i].val);
      pending_results.push_back(directed_rows[i].typed ? directed_rows[i].want : predicted);
    end

    // Segments cycle through fill, drain and mixed so full and empty both recur.
    sent     = 0;
    seg      = 0;
    hold_at  = $urandom_range(250, 400);
    pause_at = $urandom_range(700, 900);
    while (sent < RANDOM_WORDS) begin
      case (seg % 3)
        0: insert_pct = 85;
        1: insert_pct = 15;
        default: insert_pct = $urandom_range(35, 65);
      endcase
      seg_len = $urandom_range(100, 150);
      idle_on = ($urandom_range(0, 3) != 0);
      seg++;
      repeat (seg_len) begin
        if (sent >= RANDOM_WORDS - QUIET_TAIL) idle_on = 1'b0;
        if (sent == hold_at) hold_out = 1'b1;
        if (sent == pause_at) begin
          @(negedge clk);
          s_axis_tvalid = 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
        op  = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        val = pick_key();
        offer_word(op, val);
        pending_results.push_back(heap_apply(op, val));
        sent++;
        if (sent >= RANDOM_WORDS) break;
      end
    end

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("max_heap_priority_queue verification clean");
    end else begin
      $display("max_heap_priority_queue verification failed");
    end
    $finish;
  end

endmodule
